@@ rtl/hvwn_pkg.sv @@
`default_nettype none
package hvwn_pkg;

	localparam int LENGTH_BITS_DEF    = 16;
	localparam int HEADER_ID_BITS_DEF = 8;

	localparam int BYTE_BITS       = 8;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 8;
	localparam int FIFO_DEPTH_BITS = 2;
	localparam int SLOT_COUNT      = 8;

	localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_BITS-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLED = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONCAT  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FLAG    = 2'd3;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_NOT_CONFIG  = 2'd1;
	localparam logic [1:0] STATUS_NOT_PRESENT = 2'd2;

	// result slots of one item, emitted from the lowest bit up
	typedef struct packed {
		logic summary;
		logic cr_c;
		logic sp_c;
		logic byt;
		logic sp_b;
		logic cr_a;
		logic sp_a;
		logic comma;
	} hvwn_slots_t;

	typedef struct packed {
		logic [1:0] status;
		logic       rep;
	} hvwn_sum_t;

	localparam int SUM_BITS = $bits(hvwn_sum_t);

endpackage
`default_nettype wire

@@ rtl/hvwn_fifo.sv @@
`default_nettype none
module hvwn_fifo #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_BITS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int DEPTH = 1 << DEPTH_BITS;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_BITS-1:0] wr_ptr_q;
	logic [DEPTH_BITS-1:0] rd_ptr_q;
	logic [DEPTH_BITS:0]   count_q;

	assign full      = (count_q == (DEPTH_BITS+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/hvwn_front.sv @@
`default_nettype none
module hvwn_front #(
	parameter int LENGTH_BITS    = hvwn_pkg::LENGTH_BITS_DEF,
	parameter int HEADER_ID_BITS = hvwn_pkg::HEADER_ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [hvwn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hvwn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hvwn_pkg::BYTE_BITS-1:0]      data_byte,
	input  logic                                byte_valid,
	input  logic [HEADER_ID_BITS-1:0]           header_id,
	input  logic                                value_last,
	input  logic                                message_last,
	output logic                                push,
	input  logic                                push_ready,
	output hvwn_pkg::hvwn_slots_t               push_slots,
	output logic [hvwn_pkg::BYTE_BITS-1:0]      push_byte,
	output hvwn_pkg::hvwn_sum_t                 push_sum,
	output logic [LENGTH_BITS-1:0]              push_len
);
	import hvwn_pkg::*;

	localparam int CMP_BITS = (HEADER_ID_BITS < 8) ? HEADER_ID_BITS : 8;

	logic                enabled_q;
	logic [CMP_BITS-1:0] target_q;
	logic                concat_q;
	logic                flag_q;

	logic                   last_white_q;
	logic                   pending_space_q;
	logic                   pending_cr_q;
	logic [1:0]             match_count_q;
	logic                   value_start_q;
	logic [LENGTH_BITS-1:0] out_count_q;

	logic                   lw_d, ps_d, pc_d, vs_d;
	logic [1:0]             mc_d;
	logic [LENGTH_BITS-1:0] oc_d;
	hvwn_slots_t            slots;
	hvwn_sum_t              sum;
	logic [LENGTH_BITS-1:0] len;
	logic                   accept;

	always_comb begin : classify
		logic                 id_match;
		logic [1:0]           mc_new;
		logic                 kept;
		logic                 consumed;
		logic                 white;
		logic [2:0]           n;
		logic [LENGTH_BITS:0] sum_cnt;
		logic [LENGTH_BITS-1:0] oc_new;

		id_match = (header_id[CMP_BITS-1:0] == target_q);
		mc_new   = (value_start_q && id_match && match_count_q != 2'd3)
			? match_count_q + 2'd1 : match_count_q;
		kept     = enabled_q && id_match && (mc_new != 2'd0) && (concat_q || mc_new == 2'd1);
		white    = (data_byte == CH_SP) || (data_byte == CH_TAB);
		consumed = 1'b0;

		slots = '0;
		lw_d  = last_white_q;
		ps_d  = pending_space_q;
		pc_d  = pending_cr_q;
		vs_d  = 1'b0;
		mc_d  = mc_new;

		slots.comma = value_start_q && kept && concat_q && (mc_new >= 2'd2);

		if (byte_valid && kept) begin
			if (pc_d) begin
				pc_d = 1'b0;
				if (data_byte == CH_LF) begin
					consumed = 1'b1;
				end else begin
					slots.sp_a = ps_d;
					ps_d       = 1'b0;
					slots.cr_a = 1'b1;
					lw_d       = 1'b0;
				end
			end
			if (!consumed) begin
				if (data_byte == CH_CR) begin
					pc_d = 1'b1;
				end else if (white) begin
					if (!lw_d) begin
						ps_d = 1'b1;
						lw_d = 1'b1;
					end
				end else begin
					slots.sp_b = ps_d;
					ps_d       = 1'b0;
					slots.byt  = 1'b1;
					lw_d       = 1'b0;
				end
			end
		end

		// value end: flush a held CR, then restart the folding state
		if (value_last || message_last) begin
			if (pc_d && enabled_q) begin
				slots.sp_c = ps_d;
				slots.cr_c = 1'b1;
			end
			lw_d = 1'b1;
			ps_d = 1'b0;
			pc_d = 1'b0;
			vs_d = 1'b1;
		end

		n = 3'(slots.comma) + 3'(slots.sp_a) + 3'(slots.cr_a) + 3'(slots.sp_b)
			+ 3'(slots.byt) + 3'(slots.sp_c) + 3'(slots.cr_c);
		sum_cnt = {1'b0, out_count_q} + (LENGTH_BITS+1)'(n);
		oc_new  = sum_cnt[LENGTH_BITS] ? '1 : sum_cnt[LENGTH_BITS-1:0];
		oc_d    = oc_new;

		sum = '0;
		len = '0;
		if (message_last) begin
			slots.summary = 1'b1;
			if (!enabled_q) begin
				sum.status = STATUS_NOT_CONFIG;
			end else if (mc_new == 2'd0) begin
				sum.status = STATUS_NOT_PRESENT;
			end else begin
				sum.status = STATUS_OK;
				sum.rep    = flag_q && (mc_new >= 2'd2);
				len        = oc_new;
			end
			mc_d = 2'd0;
			oc_d = '0;
		end
	end

	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign push       = accept && (slots != '0);
	assign push_slots = slots;
	assign push_byte  = data_byte;
	assign push_sum   = sum;
	assign push_len   = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			target_q  <= '0;
			concat_q  <= 1'b0;
			flag_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data[0];
				CFG_TARGET:  target_q  <= cfg_data[CMP_BITS-1:0];
				CFG_CONCAT:  concat_q  <= cfg_data[0];
				CFG_FLAG:    flag_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_white_q    <= 1'b1;
			pending_space_q <= 1'b0;
			pending_cr_q    <= 1'b0;
			match_count_q   <= 2'd0;
			value_start_q   <= 1'b1;
			out_count_q     <= '0;
		end else if (accept) begin
			last_white_q    <= lw_d;
			pending_space_q <= ps_d;
			pending_cr_q    <= pc_d;
			match_count_q   <= mc_d;
			value_start_q   <= vs_d;
			out_count_q     <= oc_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/hvwn_back.sv @@
`default_nettype none
module hvwn_back #(
	parameter int LENGTH_BITS = hvwn_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  hvwn_pkg::hvwn_slots_t          q_slots,
	input  logic [hvwn_pkg::BYTE_BITS-1:0] q_byte,
	input  hvwn_pkg::hvwn_sum_t            q_sum,
	input  logic [LENGTH_BITS-1:0]         q_len,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_kind,
	output logic [hvwn_pkg::BYTE_BITS-1:0] out_byte,
	output logic [1:0]                     out_status,
	output logic                           out_rep,
	output logic [LENGTH_BITS-1:0]         out_len,
	output logic                           out_last
);
	import hvwn_pkg::*;

	logic [SLOT_COUNT-1:0]  mask_q;
	logic [BYTE_BITS-1:0]   cur_byte_q;
	hvwn_sum_t              cur_sum_q;
	logic [LENGTH_BITS-1:0] cur_len_q;

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [BYTE_BITS-1:0]   out_byte_q;
	logic [1:0]             out_status_q;
	logic                   out_rep_q;
	logic [LENGTH_BITS-1:0] out_len_q;
	logic                   out_last_q;

	logic [SLOT_COUNT-1:0] sel;
	logic [SLOT_COUNT-1:0] mask_rest;
	hvwn_slots_t           sel_s;
	logic                  out_free;
	logic                  advance;
	logic                  load;
	logic                  nxt_kind;
	logic [BYTE_BITS-1:0]  nxt_byte;

	always_comb begin
		sel = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SLOT_COUNT'(1) << i;
			end
		end
	end

	assign sel_s     = hvwn_slots_t'(sel);
	assign mask_rest = mask_q & ~sel;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = out_free && (mask_q != '0);
	// refill when idle or as the last slot of the current item goes out
	assign load      = q_valid && ((mask_q == '0) || (advance && mask_rest == '0));
	assign q_pop     = load;

	always_comb begin
		nxt_kind = 1'b0;
		priority if (sel_s.summary) begin
			nxt_kind = 1'b1;
			nxt_byte = '0;
		end else if (sel_s.byt) begin
			nxt_byte = cur_byte_q;
		end else if (sel_s.comma) begin
			nxt_byte = CH_COMMA;
		end else if (sel_s.cr_a || sel_s.cr_c) begin
			nxt_byte = CH_CR;
		end else begin
			nxt_byte = CH_SP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= q_slots;
		end else if (advance) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_byte_q <= q_byte;
			cur_sum_q  <= q_sum;
			cur_len_q  <= q_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_kind_q   <= nxt_kind;
			out_byte_q   <= nxt_byte;
			out_status_q <= nxt_kind ? cur_sum_q.status : STATUS_OK;
			out_rep_q    <= nxt_kind && cur_sum_q.rep;
			out_len_q    <= nxt_kind ? cur_len_q : '0;
			out_last_q   <= (mask_rest == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign out_status = out_status_q;
	assign out_rep    = out_rep_q;
	assign out_len    = out_len_q;
	assign out_last   = out_last_q;
endmodule
`default_nettype wire

@@ rtl/header_value_whitespace_normalizer.sv @@
// Header value whitespace normalizer.
// s_* channel: one header byte per beat. s_tdata holds data_byte then header_id,
// s_tuser holds byte_valid then value_last, s_tlast marks the message's last item.
// cfg_* channel: register writes (0 enabled, 1 target_header, 2 concatenate_repeats,
// 3 flag_repeats), always ready; write only while the block is idle.
// m_* channel: results. m_tuser is the kind (0 byte, 1 message summary); m_tdata
// holds out_byte, status, repeat_flag, total_length; m_tlast marks the last
// result caused by one input beat.
// Throughput: one input beat per cycle while the queue is not full; one result
// beat per cycle while the receiver is ready. A beat that causes k results holds
// the output side until all k are out; a four-entry queue between the classifier
// and the emitter absorbs the difference. Results pass the queue, the slot mask and the output register.
// Reset clears folding state, registers and queue; no results are pending.
// A stalled receiver holds the output register, fills the queue, then drops
// s_tready until space returns.
`default_nettype none
module header_value_whitespace_normalizer #(
	parameter int LENGTH_BITS    = hvwn_pkg::LENGTH_BITS_DEF,
	parameter int HEADER_ID_BITS = hvwn_pkg::HEADER_ID_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [hvwn_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [hvwn_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// data_byte, header_id
	input  logic [((8+HEADER_ID_BITS+7)/8)*8-1:0]     s_tdata,
	// byte_valid, value_last
	input  logic [1:0]                                s_tuser,
	input  logic                                      s_tlast,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// out_byte, status, repeat_flag, total_length
	output logic [((11+LENGTH_BITS+7)/8)*8-1:0]       m_tdata,
	// item_kind
	output logic                                      m_tuser,
	output logic                                      m_tlast
);
	import hvwn_pkg::*;

	localparam int OUT_BITS   = ((11 + LENGTH_BITS + 7) / 8) * 8;
	localparam int ENTRY_BITS = LENGTH_BITS + SUM_BITS + BYTE_BITS + SLOT_COUNT;

	logic                   push;
	logic                   fifo_full;
	hvwn_slots_t            f_slots;
	logic [BYTE_BITS-1:0]   f_byte;
	hvwn_sum_t              f_sum;
	logic [LENGTH_BITS-1:0] f_len;
	logic [ENTRY_BITS-1:0]  wdata;
	logic [ENTRY_BITS-1:0]  rdata;
	logic                   q_valid;
	logic                   q_pop;

	logic                   o_kind;
	logic [BYTE_BITS-1:0]   o_byte;
	logic [1:0]             o_status;
	logic                   o_rep;
	logic [LENGTH_BITS-1:0] o_len;

	assign cfg_ready = 1'b1;

	hvwn_front #(
		.LENGTH_BITS   (LENGTH_BITS),
		.HEADER_ID_BITS(HEADER_ID_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata[7:0]),
		.byte_valid  (s_tuser[0]),
		.header_id   (s_tdata[8 +: HEADER_ID_BITS]),
		.value_last  (s_tuser[1]),
		.message_last(s_tlast),
		.push        (push),
		.push_ready  (!fifo_full),
		.push_slots  (f_slots),
		.push_byte   (f_byte),
		.push_sum    (f_sum),
		.push_len    (f_len)
	);

	assign wdata = {f_len, f_sum, f_byte, f_slots};

	hvwn_fifo #(
		.WIDTH     (ENTRY_BITS),
		.DEPTH_BITS(FIFO_DEPTH_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wdata),
		.full     (fifo_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.rdata    (rdata)
	);

	hvwn_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_slots   (hvwn_slots_t'(rdata[SLOT_COUNT-1:0])),
		.q_byte    (rdata[SLOT_COUNT +: BYTE_BITS]),
		.q_sum     (hvwn_sum_t'(rdata[SLOT_COUNT+BYTE_BITS +: SUM_BITS])),
		.q_len     (rdata[SLOT_COUNT+BYTE_BITS+SUM_BITS +: LENGTH_BITS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (o_kind),
		.out_byte  (o_byte),
		.out_status(o_status),
		.out_rep   (o_rep),
		.out_len   (o_len),
		.out_last  (m_tlast)
	);

	assign m_tuser = o_kind;
	assign m_tdata = OUT_BITS'({o_len, o_rep, o_status, o_byte});

`ifndef SYNTHESIS
	a_summary_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("summary beat without tlast");

	a_byte_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[8 +: 3 + LENGTH_BITS] == '0)
		else $error("byte beat carries summary fields");

	a_failed_status_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (m_tdata[9:8] != STATUS_OK)
		|-> (m_tdata[11 +: LENGTH_BITS] == '0) && !m_tdata[10])
		else $error("length or repeat flag with failing status");
`endif
endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import hvwn_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic [7:0] hid;
		logic       vlast;
		logic       mlast;
	} hdr_beat_t;

	typedef struct {
		logic        kind;
		logic [7:0]  ch;
		logic [1:0]  status;
		logic        rep;
		logic [15:0] len;
		logic        last;
	} fold_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	header_value_whitespace_normalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	hdr_beat_t    pending_beats[$];
	hdr_beat_t    beat_on_bus;
	fold_result_t expected_results[$];
	fold_result_t held_result;
	fold_result_t next_result;
	logic         have_held = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int queued_items = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// shadow registers
	logic       sh_enabled = 1'b0;
	logic [7:0] sh_target = '0;
	logic       sh_concat = 1'b0;
	logic       sh_flag = 1'b0;

	// folding state
	logic        fold_last_white = 1'b1;
	logic        fold_pend_sp = 1'b0;
	logic        fold_pend_cr = 1'b0;
	logic [1:0]  fold_matches = '0;
	logic        fold_value_start = 1'b1;
	logic [15:0] fold_out_count = '0;

	// keep one result back so the final one of a beat can carry run_last
	task automatic stage_result(input fold_result_t r);
		if (have_held)
			expected_results.push_back(held_result);
		held_result = r;
		have_held = 1'b1;
	endtask

	task automatic emit_folded(input logic [7:0] c);
		stage_result('{1'b0, c, 2'd0, 1'b0, 16'd0, 1'b0});
		if (fold_out_count != 16'hFFFF)
			fold_out_count++;
	endtask

	task automatic fold_beat(input hdr_beat_t b);
		logic id_hit;
		logic kept;
		logic eaten;
		fold_result_t summary;
		id_hit = (b.hid == sh_target);
		if (fold_value_start && id_hit && fold_matches != 2'd3)
			fold_matches++;
		kept = sh_enabled && id_hit && fold_matches != 2'd0 &&
			(sh_concat || fold_matches == 2'd1);
		if (fold_value_start && kept && sh_concat && fold_matches >= 2'd2)
			emit_folded(CH_COMMA);
		fold_value_start = 1'b0;

		if (b.valid && kept) begin
			eaten = 1'b0;
			if (fold_pend_cr) begin
				fold_pend_cr = 1'b0;
				if (b.data == CH_LF) begin
					eaten = 1'b1;
				end else begin
					if (fold_pend_sp) begin
						emit_folded(CH_SP);
						fold_pend_sp = 1'b0;
					end
					emit_folded(CH_CR);
					fold_last_white = 1'b0;
				end
			end
			if (!eaten) begin
				if (b.data == CH_CR) begin
					fold_pend_cr = 1'b1;
				end else if (b.data == CH_SP || b.data == CH_TAB) begin
					if (!fold_last_white) begin
						fold_pend_sp = 1'b1;
						fold_last_white = 1'b1;
					end
				end else begin
					if (fold_pend_sp) begin
						emit_folded(CH_SP);
						fold_pend_sp = 1'b0;
					end
					emit_folded(b.data);
					fold_last_white = 1'b0;
				end
			end
		end

		// a held CR survives value end, a held space does not unless a CR follows it
		if (b.vlast || b.mlast) begin
			if (fold_pend_cr && sh_enabled) begin
				if (fold_pend_sp)
					emit_folded(CH_SP);
				emit_folded(CH_CR);
			end
			fold_last_white = 1'b1;
			fold_pend_sp = 1'b0;
			fold_pend_cr = 1'b0;
			fold_value_start = 1'b1;
		end

		if (b.mlast) begin
			summary = '{1'b1, 8'd0, STATUS_OK, 1'b0, 16'd0, 1'b0};
			if (!sh_enabled) begin
				summary.status = STATUS_NOT_CONFIG;
			end else if (fold_matches == 2'd0) begin
				summary.status = STATUS_NOT_PRESENT;
			end else begin
				summary.rep = sh_flag && fold_matches >= 2'd2;
				summary.len = fold_out_count;
			end
			stage_result(summary);
			fold_matches = '0;
			fold_out_count = '0;
		end

		if (have_held) begin
			held_result.last = 1'b1;
			expected_results.push_back(held_result);
			have_held = 1'b0;
		end
	endtask

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatches++;
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				fold_beat(beat_on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_on_bus = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {beat_on_bus.hid, beat_on_bus.data};
					s_tuser <= {beat_on_bus.vlast, beat_on_bus.valid};
					s_tlast <= beat_on_bus.mlast;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: kind %0d data %h last %0d",
						m_tuser, m_tdata, m_tlast);
					mismatches++;
				end else begin
					next_result = expected_results.pop_front();
					check_field("item_kind", next_result.kind, m_tuser);
					check_field("out_byte", next_result.ch, m_tdata[7:0]);
					check_field("status", next_result.status, m_tdata[9:8]);
					check_field("repeat_flag", next_result.rep, m_tdata[10]);
					check_field("total_length", next_result.len, m_tdata[26:11]);
					check_field("run_last", next_result.last, m_tlast);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ENABLED: sh_enabled = val[0];
			CFG_TARGET:  sh_target = val;
			CFG_CONCAT:  sh_concat = val[0];
			CFG_FLAG:    sh_flag = val[0];
			default: ;
		endcase
	endtask

	task automatic queue_beat(input logic [7:0] data, input logic valid,
			input logic [7:0] hid, input logic vlast, input logic mlast);
		hdr_beat_t b;
		b.data = data;
		b.valid = valid;
		b.hid = hid;
		b.vlast = vlast;
		b.mlast = mlast;
		pending_beats.push_back(b);
		queued_items++;
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 22) return CH_SP;
		if (r < 32) return CH_TAB;
		if (r < 44) return CH_CR;
		if (r < 54) return CH_LF;
		if (r < 60) return CH_COMMA;
		if (r < 88) return 8'($urandom_range(33, 126));
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed messages; some values lose value_last or carry stray ids
	task automatic gen_message(input logic [7:0] tgt);
		int nvals;
		int nbytes;
		logic empty;
		logic [7:0] vid;
		logic [7:0] hid;
		logic final_v;
		logic last_i;
		logic vl;
		nvals = $urandom_range(1, 4);
		for (int v = 0; v < nvals; v++) begin
			final_v = (v == nvals - 1);
			vid = ($urandom_range(99) < 60) ? tgt : 8'($urandom_range(255));
			empty = ($urandom_range(9) == 0);
			nbytes = empty ? 1 : $urandom_range(1, 8);
			for (int i = 0; i < nbytes; i++) begin
				last_i = (i == nbytes - 1);
				hid = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : vid;
				vl = last_i && (final_v ? ($urandom_range(1) == 1) : ($urandom_range(19) != 0));
				queue_beat(pick_char(), !empty && ($urandom_range(19) != 0), hid, vl,
					last_i && final_v);
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic en, input logic [7:0] tgt, input logic concat,
			input logic flag, input int send_pct, input int recv_pct, input int goal,
			input logic pause);
		write_reg(CFG_ENABLED, {7'd0, en});
		write_reg(CFG_TARGET, tgt);
		write_reg(CFG_CONCAT, {7'd0, concat});
		write_reg(CFG_FLAG, {7'd0, flag});
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queued_items = 0;
		// hold the sender until the output side has fully caught up
		if (pause) begin
			while (queued_items < goal / 2)
				gen_message(tgt);
			wait_drained();
		end
		while (queued_items < goal)
			gen_message(tgt);
		wait_drained();
	endtask

	initial begin
		logic [7:0] tg;
		tg = 8'h2A;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_ENABLED, 8'd1);
		write_reg(CFG_TARGET, tg);
		write_reg(CFG_CONCAT, 8'd1);
		write_reg(CFG_FLAG, 8'd1);
		@(negedge clk);
		// leading, inner and trailing white, a CR-LF pair
		queue_beat(CH_SP, 1'b1, tg, 1'b0, 1'b0);
		queue_beat("a", 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_SP, 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_TAB, 1'b1, tg, 1'b0, 1'b0);
		queue_beat("b", 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_CR, 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_LF, 1'b1, tg, 1'b0, 1'b0);
		queue_beat("c", 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_SP, 1'b1, tg, 1'b1, 1'b0);
		// empty value still gets its comma
		queue_beat(8'hFF, 1'b0, tg, 1'b1, 1'b0);
		// other headers, extreme bytes and ids
		queue_beat(8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
		queue_beat(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
		// space then CR held to value end
		queue_beat("d", 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_SP, 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_CR, 1'b1, tg, 1'b1, 1'b0);
		// lone LF, a stray id inside a value, message end without value end
		queue_beat(CH_LF, 1'b1, tg, 1'b0, 1'b0);
		queue_beat("e", 1'b1, 8'h00, 1'b0, 1'b0);
		queue_beat(8'hFF, 1'b1, tg, 1'b0, 1'b0);
		queue_beat(CH_CR, 1'b1, tg, 1'b0, 1'b0);
		queue_beat("f", 1'b1, tg, 1'b0, 1'b1);
		// message with no matching header
		queue_beat("g", 1'b1, 8'h00, 1'b1, 1'b1);
		wait_drained();

		run_phase(1'b1, 8'h00, 1'b0, 1'b0, 0, 0, 35, 1'b0);
		run_phase(1'b1, 8'hFF, 1'b1, 1'b1, 52, 0, 35, 1'b0);
		run_phase(1'b0, 8'h55, 1'b1, 1'b1, 0, 52, 25, 1'b0);
		run_phase(1'b1, 8'hAA, 1'b1, 1'b0, 6, 6, 35, 1'b0);
		run_phase(1'b1, 8'($urandom_range(255)), 1'b0, 1'b1, 52, 0, 35, 1'b1);
		run_phase(1'b1, 8'($urandom_range(255)), 1'b1, 1'b1, 0, 52, 35, 1'b0);
		run_phase(1'b0, 8'h00, 1'b0, 1'b0, 6, 6, 20, 1'b0);
		run_phase(1'b1, 8'($urandom_range(255)), 1'b1, 1'b1, 0, 0, 35, 1'b0);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
